/* hdl/pprl_pkg.sv */
// Shared types, constants and helpers for the preemptive priority resource lock.
package pprl_pkg;

  localparam int PRIORITY_BITS = 8;
  localparam int PRIO_W        = PRIORITY_BITS + 1;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = PRIORITY_BITS;
  localparam int MARK_W        = 3;

  typedef enum logic [1:0] {
    ACT_QUERY   = 2'd0,
    ACT_ACQUIRE = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    SRC_NONE     = 2'd0,
    SRC_VECTOR   = 2'd1,
    SRC_WAYPOINT = 2'd2,
    SRC_SAFE     = 2'd3
  } src_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REMOTE_VECTOR   = 3'd0,
    CFG_REMOTE_WAYPOINT = 3'd1,
    CFG_LOCAL_VECTOR    = 3'd2,
    CFG_LOCAL_WAYPOINT  = 3'd3,
    CFG_SAFE            = 3'd4
  } cfg_idx_t;

  typedef logic [PRIORITY_BITS-1:0] prio_t;
  typedef logic signed [PRIO_W-1:0] hprio_t;
  typedef logic [MARK_W-1:0]        mark_t;

  // Revoked-mark bit that belongs to a source; the empty source owns none.
  function automatic mark_t mark_of(input src_t src);
    mark_t m;
    m = '0;
    case (src)
      SRC_VECTOR:   m = 3'b001;
      SRC_WAYPOINT: m = 3'b010;
      SRC_SAFE:     m = 3'b100;
      default:      m = '0;
    endcase
    return m;
  endfunction

endpackage

/* hdl/preemptive_priority_resource_lock_core.sv */
// Preemptive priority lock for one shared resource with three requesters.
//
// Usage: a request (action, source, command class) enters on the in_ channel
// under valid/ready and is held in an input register. While it waits there the
// lock decision is made against the current holder, its priority and the
// revoked marks; the state is updated and the answer is loaded into the
// output register at the same edge. The out_ channel presents granted,
// preempted, the holder after the request, whether the requester owns the
// resource and the revoked marks.
// Each result passes through the input register and then the output register
// before out_valid rises. Throughput is one request per cycle while out_ready
// is high, set by the single decision stage; back-to-back requests see each
// other's state updates with no gap.
// Priorities are written through the cfg_ port at any idle time; writes to
// indexes above four are dropped. Reset clears all priorities, frees the
// resource and clears the revoked marks.
// When the receiver holds out_ready low the output register keeps its
// result, one more request may wait in the input register, and in_ready
// then drops until the output drains.
module preemptive_priority_resource_lock_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_action,
  input  logic [1:0]                        in_source,
  input  logic                              in_command_class,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_granted,
  output logic                              out_preempted,
  output logic [1:0]                        out_holder_now,
  output logic                              out_source_owns,
  output logic [2:0]                        out_revoked_mask,
  input  logic                              cfg_we,
  input  logic [pprl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pprl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pprl_pkg::*;

  prio_t   rv_prio_r, rw_prio_r, lv_prio_r, lw_prio_r, safe_prio_r;

  logic    s1_valid_r;
  logic [1:0] s1_action_r;
  src_t    s1_src_r;
  logic    s1_cls_r;

  src_t    holder_r, holder_nxt;
  hprio_t  holder_prio_r, holder_prio_nxt;
  mark_t   revoked_r, revoked_nxt;
  hprio_t  req_prio;
  logic    would_grant;
  logic    granted, preempted;

  logic    out_valid_r;
  logic    out_granted_r, out_preempted_r, out_owns_r;
  src_t    out_holder_r;
  mark_t   out_revoked_r;
  logic    out_load;

  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_prio_r   <= '0;
      rw_prio_r   <= '0;
      lv_prio_r   <= '0;
      lw_prio_r   <= '0;
      safe_prio_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REMOTE_VECTOR:   rv_prio_r   <= cfg_wdata;
        CFG_REMOTE_WAYPOINT: rw_prio_r   <= cfg_wdata;
        CFG_LOCAL_VECTOR:    lv_prio_r   <= cfg_wdata;
        CFG_LOCAL_WAYPOINT:  lw_prio_r   <= cfg_wdata;
        CFG_SAFE:            safe_prio_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r <= in_action;
      s1_src_r    <= src_t'(in_source);
      s1_cls_r    <= in_command_class;
    end
  end

  always_comb begin
    case (s1_src_r)
      SRC_VECTOR:   req_prio = hprio_t'({1'b0, (s1_cls_r ? rv_prio_r : lv_prio_r)});
      SRC_WAYPOINT: req_prio = hprio_t'({1'b0, (s1_cls_r ? rw_prio_r : lw_prio_r)});
      SRC_SAFE:     req_prio = hprio_t'({1'b0, safe_prio_r});
      default:      req_prio = '1;
    endcase
  end

  always_comb begin
    holder_nxt      = holder_r;
    holder_prio_nxt = holder_prio_r;
    revoked_nxt     = revoked_r;
    granted         = 1'b0;
    preempted       = 1'b0;
    would_grant     = (holder_r == SRC_NONE) || (holder_r == s1_src_r) ||
                      (req_prio > holder_prio_r);
    case (s1_action_r)
      ACT_QUERY: begin
        granted = would_grant;
      end
      ACT_ACQUIRE: begin
        if ((holder_r == s1_src_r) || (holder_r == SRC_NONE)) begin
          holder_nxt      = s1_src_r;
          holder_prio_nxt = req_prio;
          revoked_nxt     = revoked_r & ~mark_of(s1_src_r);
          granted         = 1'b1;
        end else if (req_prio > holder_prio_r) begin
          holder_nxt      = s1_src_r;
          holder_prio_nxt = req_prio;
          revoked_nxt     = (revoked_r | mark_of(holder_r)) & ~mark_of(s1_src_r);
          granted         = 1'b1;
          preempted       = 1'b1;
        end
      end
      ACT_RELEASE: begin
        if (holder_r == s1_src_r) begin
          holder_nxt      = SRC_NONE;
          holder_prio_nxt = '1;
        end
        revoked_nxt = revoked_r & ~mark_of(s1_src_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holder_r      <= SRC_NONE;
      holder_prio_r <= '1;
      revoked_r     <= '0;
    end else if (out_load) begin
      holder_r      <= holder_nxt;
      holder_prio_r <= holder_prio_nxt;
      revoked_r     <= revoked_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_granted_r   <= granted;
      out_preempted_r <= preempted;
      out_holder_r    <= holder_nxt;
      out_owns_r      <= (s1_src_r != SRC_NONE) && (holder_nxt == s1_src_r);
      out_revoked_r   <= revoked_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_preempted    = out_preempted_r;
  assign out_holder_now   = out_holder_r;
  assign out_source_owns  = out_owns_r;
  assign out_revoked_mask = out_revoked_r;

  // A free resource always carries the all-ones priority (-1), below any configured priority.
  a_free_prio: assert property (@(posedge clk) disable iff (!rst_n)
    (holder_r == SRC_NONE) |-> (holder_prio_r == '1))
    else $error("free resource with a nonempty priority");

  // The current holder never carries its own revoked mark.
  a_holder_not_revoked: assert property (@(posedge clk) disable iff (!rst_n)
    (revoked_r & mark_of(holder_r)) == '0)
    else $error("holder carries a revoked mark");

  // A preemption is always a grant and always changes the holder.
  a_preempt_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && preempted) |-> (granted && (holder_nxt != holder_r)))
    else $error("preemption without grant or holder change");

  // State only changes when a request leaves the decision stage.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(out_load) |-> ($stable(holder_r) && $stable(revoked_r)))
    else $error("lock state changed without a request");

  // A stalled output with a waiting request blocks the input.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages are full");

endmodule
